FILE: sv/streaming_top_k_select_defines.svh
// assertion macros for the streaming top-k select block
// no dependencies; taken in by files that carry concurrent assertions
`ifndef STREAMING_TOP_K_SELECT_DEFINES_SVH
`define STREAMING_TOP_K_SELECT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define STKS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define STKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/stks_pkg.sv
// shared types, constants and helpers for the streaming top-k select block
// no dependencies; used by stks_cell and streaming_top_k_select
package stks_pkg;

   // fixed field widths
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 4;
   localparam int KCFG_W    = 6;
   // effective k is at most 63, so seven bits always hold it
   localparam int KEFF_W    = 7;

   // default number of cells in the chain
   localparam int MAX_K_DEFAULT = 32;

   // register indexes of the write port
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LARGEST  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_K_IN_USE      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_USE_GIVEN_IDS = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BASE    = CSR_IDX_W'(3);

   // input item kinds
   localparam logic KIND_CANDIDATE = 1'b0;
   localparam logic KIND_FINISH    = 1'b1;

   // marker id of an empty slot
   localparam logic [DATA_W-1:0] EMPTY_ID = {DATA_W{1'b1}};

   // one kept entry
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] distance;
      logic        [DATA_W-1:0] id;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, distance: '0, id: EMPTY_ID};

   // candidate broadcast to every cell
   typedef struct packed {
      logic signed [DATA_W-1:0] distance;
      logic        [DATA_W-1:0] id;
   } cand_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic keep_largest;
      logic clear_all;
      logic insert;
      logic shift_out;
   } cell_ctl_type;

   // distance that an empty slot stands for
   function automatic logic signed [DATA_W-1:0] extreme_dist(input logic keep_largest);
      logic signed [DATA_W-1:0] res;
      res = keep_largest ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      return res;
   endfunction

endpackage

FILE: sv/streaming_top_k_select.sv
// channel | ports                                         | transfer when
// req     | req_kind, req_distance, req_item_id           | req_valid & req_ready
// rsp     | rsp_out_distance, rsp_out_id, rsp_last        | rsp_valid & rsp_ready
// csr     | csr_wr_en, csr_index, csr_wdata (write only)  | csr_wr_en
//
// a candidate is taken every cycle while no list is being emitted; all cells
// compare it at once and the chain shifts one slot to make room.
// a finish item blocks req until all k results are out: each result is one
// left shift of the chain out of cell 0, one per cycle while rsp_ready is high.
// rsp_ready low holds the chain and the output register; candidates still flow
// while the last result of a list waits. reset is synchronous and empties every
// cell through its valid bit, with no clearing pass.
//
// top level of the streaming top-k select block
// depends on stks_pkg, stks_cell and streaming_top_k_select_defines.svh
`include "streaming_top_k_select_defines.svh"

module streaming_top_k_select #(
   parameter int MAX_K = stks_pkg::MAX_K_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [stks_pkg::DATA_W-1:0]   req_distance,
   input  logic        [stks_pkg::DATA_W-1:0]   req_item_id,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [stks_pkg::DATA_W-1:0]   rsp_out_distance,
   output logic        [stks_pkg::DATA_W-1:0]   rsp_out_id,
   output logic                                 rsp_last,
   // register writes
   input  logic                                 csr_wr_en,
   input  logic        [stks_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [stks_pkg::DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // configuration registers
   logic                          keep_largest_ff;
   logic [stks_pkg::KCFG_W-1:0]   k_in_use_ff;
   logic                          use_given_ids_ff;
   logic [stks_pkg::DATA_W-1:0]   index_base_ff;
   logic [stks_pkg::DATA_W-1:0]   arrival_pos_ff;

   state_type                     state_ff;
   logic [CNT_W-1:0]              emit_cnt_ff;
   logic                          rsp_valid_ff;
   logic signed [stks_pkg::DATA_W-1:0] rsp_dist_ff;
   logic [stks_pkg::DATA_W-1:0]   rsp_id_ff;
   logic                          rsp_last_ff;

   logic [stks_pkg::KEFF_W-1:0]   k_raw;
   logic [stks_pkg::KEFF_W-1:0]   k_eff;
   logic                          req_fire;
   logic                          cand_fire;
   logic                          finish_fire;
   logic                          emit_load;
   logic                          emit_last;
   logic                          mode_write;

   stks_pkg::cell_ctl_type        ctl;
   stks_pkg::cand_type            cand;
   stks_pkg::entry_type           entries [MAX_K];
   logic [MAX_K-1:0]              better_vec;
   logic [MAX_K-1:0]              valid_vec;

   // effective k: zero acts as one, capped at the chain length
   assign k_raw = stks_pkg::KEFF_W'(k_in_use_ff);
   always_comb begin
      priority if (k_raw == '0) begin
         k_eff = stks_pkg::KEFF_W'(1);
      end else if (k_raw > stks_pkg::KEFF_W'(MAX_K)) begin
         k_eff = stks_pkg::KEFF_W'(MAX_K);
      end else begin
         k_eff = k_raw;
      end
   end

   // handshake decode
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign cand_fire   = req_fire && (req_kind == stks_pkg::KIND_CANDIDATE);
   assign finish_fire = req_fire && (req_kind == stks_pkg::KIND_FINISH);
   assign emit_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last   = (stks_pkg::KEFF_W'(emit_cnt_ff) + stks_pkg::KEFF_W'(1)) == k_eff;
   assign mode_write  = csr_wr_en && (csr_index == stks_pkg::CSR_KEEP_LARGEST);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_largest_ff  <= 1'b0;
         k_in_use_ff      <= stks_pkg::KCFG_W'(32);
         use_given_ids_ff <= 1'b1;
         index_base_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stks_pkg::CSR_KEEP_LARGEST:  keep_largest_ff  <= csr_wdata[0];
            stks_pkg::CSR_K_IN_USE:      k_in_use_ff      <= csr_wdata[stks_pkg::KCFG_W-1:0];
            stks_pkg::CSR_USE_GIVEN_IDS: use_given_ids_ff <= csr_wdata[0];
            stks_pkg::CSR_INDEX_BASE:    index_base_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // arrival position counts candidates since the last finish
   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_pos_ff <= '0;
      end else if (finish_fire) begin
         arrival_pos_ff <= '0;
      end else if (cand_fire) begin
         arrival_pos_ff <= arrival_pos_ff + stks_pkg::DATA_W'(1);
      end
   end

   // candidate broadcast and chain command
   assign cand.distance = req_distance;
   assign cand.id       = use_given_ids_ff ? req_item_id : (index_base_ff + arrival_pos_ff);

   assign ctl.keep_largest = keep_largest_ff;
   assign ctl.clear_all    = mode_write || (emit_load && emit_last);
   assign ctl.insert       = cand_fire;
   assign ctl.shift_out    = emit_load;

   // the insertion chain, best entry in cell 0
   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      logic                in_use;
      logic                left_better;
      stks_pkg::entry_type left_entry;
      stks_pkg::entry_type right_entry;

      assign in_use = stks_pkg::KEFF_W'(i) < k_eff;

      if (i == 0) begin : g_head
         assign left_better = 1'b0;
         assign left_entry  = stks_pkg::EMPTY_ENTRY;
      end else begin : g_body
         assign left_better = better_vec[i-1];
         assign left_entry  = entries[i-1];
      end

      if (i == MAX_K - 1) begin : g_tail
         assign right_entry = stks_pkg::EMPTY_ENTRY;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      stks_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .cand        (cand),
         .in_use      (in_use),
         .left_better (left_better),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .better      (better_vec[i]),
         .entry       (entries[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_dist_ff  <= entries[0].valid ? entries[0].distance
                                             : stks_pkg::extreme_dist(keep_largest_ff);
            rsp_id_ff    <= entries[0].valid ? entries[0].id : stks_pkg::EMPTY_ID;
            rsp_last_ff  <= emit_last;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (finish_fire) begin
                  state_ff    <= ST_EMIT;
                  emit_cnt_ff <= '0;
               end
            end
            ST_EMIT: begin
               if (emit_load) begin
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end
                  emit_cnt_ff <= emit_cnt_ff + CNT_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_distance = rsp_dist_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

   // assertions
   `STKS_ASSERT_NEXT(a_finish_starts_emit, clock, reset, finish_fire,
      (state_ff == ST_EMIT) && (emit_cnt_ff == '0), "finish did not start emission")
   `STKS_ASSERT_NEXT(a_last_clears_chain, clock, reset, emit_load && emit_last,
      (valid_vec == '0) && (state_ff == ST_IDLE), "chain not empty after last result")
   `STKS_ASSERT_NOW(a_valid_prefix, clock, reset, 1'b1,
      ((valid_vec + MAX_K'(1)) & valid_vec) == '0, "kept entries not packed at the head")

endmodule

FILE: sv/stks_cell.sv
// one slot of the sorted insertion chain: holds an entry and its valid bit
// depends on stks_pkg; instantiated by streaming_top_k_select
module stks_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  stks_pkg::cell_ctl_type  ctl,
   input  stks_pkg::cand_type      cand,
   input  logic                    in_use,
   input  logic                    left_better,
   input  stks_pkg::entry_type     left_entry,
   input  stks_pkg::entry_type     right_entry,
   output logic                    better,
   output stks_pkg::entry_type     entry
);

   stks_pkg::entry_type      entry_ff;
   stks_pkg::entry_type      entry_in;
   logic signed [stks_pkg::DATA_W-1:0] eff_dist;

   // an empty slot compares as the extreme value of the mode
   assign eff_dist = entry_ff.valid ? entry_ff.distance
                                    : stks_pkg::extreme_dist(ctl.keep_largest);
   assign better   = ctl.keep_largest ? (cand.distance > eff_dist) : (cand.distance < eff_dist);

   // next entry: clear, shift toward the head, or insert with push toward the tail
   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.clear_all || !in_use) begin
         entry_in.valid = 1'b0;
      end else if (ctl.shift_out) begin
         entry_in = right_entry;
      end else if (ctl.insert && better) begin
         if (left_better) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid    = 1'b1;
            entry_in.distance = cand.distance;
            entry_in.id       = cand.id;
         end
      end
   end

   // valid bit is reset, payload is not
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.distance <= entry_in.distance;
      entry_ff.id       <= entry_in.id;
   end

   assign entry = entry_ff;

endmodule
